FILE: sv/dobq_pkg.sv
package dobq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned SIZE_W = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned ENT_CFG_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = CFG_IDX_W'(1);

  localparam logic [ENT_CFG_W-1:0] MAX_ENTRIES_RST = ENT_CFG_W'(64);
  localparam logic [SIZE_W-1:0]    MAX_BYTES_RST   = SIZE_W'(65536);

  // Command codes
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_DROP = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_TOOBIG = 2'd1;
  localparam logic [1:0] STS_EMPTY  = 2'd2;

  // Depth of the op queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_REJECT,
    OP_GET,
    OP_DROP,
    OP_NOP
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } op_t;

  typedef struct packed {
    logic              done;
    logic [1:0]        status;
    logic [CNT_W-1:0]  dropped;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    logic [SIZE_W-1:0] bytes;
  } result_t;

endpackage

FILE: sv/drop_oldest_byte_budget_queue_core.sv
// Flow: reject, empty and unknown commands are answered from the back's idle state,
//   get/drop from its pop state; a put first evicts oldest words (one per cycle in the back FSM).
// The back FSM handles one word at a time; a 2-deep op queue and the front register let up
//   to three words wait behind the one in the back FSM before busy_o rises.
// Reset: rst_ni (async, active low) empties the queue and restores max_entries 64,
//   max_bytes 65536. Results are single-cycle strobes on done_o; the receiver cannot stall.
module drop_oldest_byte_budget_queue_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     command_i,
  input  logic [dobq_pkg::SIZE_W-1:0]    item_size_i,
  input  logic [dobq_pkg::TAG_W-1:0]     item_tag_i,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [dobq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dobq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // result strobe
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [dobq_pkg::CNT_W-1:0]     dropped_count_o,
  output logic [dobq_pkg::TAG_W-1:0]     out_tag_o,
  output logic [dobq_pkg::SIZE_W-1:0]    out_size_o,
  output logic [dobq_pkg::CNT_W-1:0]     entry_count_o,
  output logic [dobq_pkg::SIZE_W-1:0]    byte_total_o
);
  import dobq_pkg::*;

  // Config registers. The entry limit is clamped when written (zero acts as one,
  // anything above DEPTH as DEPTH), so the back compares against it directly.
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [SIZE_W-1:0]    max_bytes_q;
  logic [ENT_CFG_W-1:0] ent_wr;

  // front -> op queue -> back
  logic    front_ready, front_valid;
  op_t     front_op;
  logic    q_ready, q_valid, q_pop;
  op_t     q_op;
  logic    back_idle;
  result_t res;

  assign ent_wr = cfg_wdata_i[ENT_CFG_W-1:0];

  always_comb begin
    if (ent_wr == '0) begin
      limit_d = CNT_W'(1);
    end else if ({{(32 - ENT_CFG_W){1'b0}}, ent_wr} > 32'(DEPTH)) begin
      limit_d = CNT_W'(DEPTH);
    end else begin
      limit_d = CNT_W'(ent_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= (32'(MAX_ENTRIES_RST) > 32'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(MAX_ENTRIES_RST);
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_ENTRIES: limit_q     <= limit_d;
        REG_MAX_BYTES:   max_bytes_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front: registers the word and classifies it (oversize puts rejected up front).
  dobq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .item_size_i (item_size_i),
    .item_tag_i  (item_tag_i),
    .max_bytes_i (max_bytes_q),
    .ready_o     (front_ready),
    .op_valid_o  (front_valid),
    .op_o        (front_op),
    .op_ready_i  (q_ready)
  );

  // Short op queue decoupling front from the back FSM.
  dobq_opq u_opq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (front_valid),
    .push_op_i (front_op),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .op_o      (q_op),
    .pop_i     (q_pop)
  );

  // Back: descriptor ring, head/tail, counters and the eviction loop.
  dobq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .limit_i     (limit_q),
    .max_bytes_i (max_bytes_q),
    .idle_o      (back_idle),
    .res_o       (res)
  );

  // Hold off new words once the front register and the op queue are full.
  // While the back works, the queue stalls; idle only gates nothing here.
  assign busy_o = !front_ready || (!back_idle && !q_ready && front_valid);

  assign done_o          = res.done;
  assign status_o        = res.status;
  assign dropped_count_o = res.dropped;
  assign out_tag_o       = res.tag;
  assign out_size_o      = res.size;
  assign entry_count_o   = res.count;
  assign byte_total_o    = res.bytes;

endmodule

FILE: sv/dobq_front.sv
module dobq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  command_i,
  input  logic [dobq_pkg::SIZE_W-1:0] item_size_i,
  input  logic [dobq_pkg::TAG_W-1:0]  item_tag_i,
  input  logic [dobq_pkg::SIZE_W-1:0] max_bytes_i,
  output logic                        ready_o,
  output logic                        op_valid_o,
  output dobq_pkg::op_t               op_o,
  input  logic                        op_ready_i
);
  import dobq_pkg::*;

  logic     valid_q, valid_d;
  op_t      op_q, op_d;
  op_kind_e kind;
  logic     take;

  // oversize puts are settled here; the back never uses their size
  always_comb begin
    case (command_i)
      CMD_PUT:  kind = (item_size_i > max_bytes_i) ? OP_REJECT : OP_PUT;
      CMD_GET:  kind = OP_GET;
      CMD_DROP: kind = OP_DROP;
      default:  kind = OP_NOP;
    endcase
  end

  assign ready_o = !valid_q || op_ready_i;
  assign take    = start_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (valid_q && op_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      op_d    = '{kind: kind, size: item_size_i, tag: item_tag_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

FILE: sv/dobq_opq.sv
module dobq_opq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dobq_pkg::op_t push_op_i,
  output logic          ready_o,
  output logic          valid_o,
  output dobq_pkg::op_t op_o,
  input  logic          pop_i
);
  import dobq_pkg::*;

  op_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_op_i;
    end
  end

endmodule

FILE: sv/dobq_back.sv
module dobq_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        op_valid_i,
  input  dobq_pkg::op_t               op_i,
  output logic                        op_pop_o,
  input  logic [dobq_pkg::CNT_W-1:0]  limit_i,
  input  logic [dobq_pkg::SIZE_W-1:0] max_bytes_i,
  output logic                        idle_o,
  output dobq_pkg::result_t           res_o
);
  import dobq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUT
  } state_e;

  state_e            state_q;
  op_t               cur_q;
  logic [IDX_W-1:0]  head_q, head_d, tail_q;
  logic [CNT_W-1:0]  held_q, dropped_q;
  logic [SIZE_W-1:0] bytes_q;
  result_t           res_q;

  logic [TAG_W-1:0]  tag_mem  [DEPTH];
  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [TAG_W-1:0]  rd_tag_q;
  logic [SIZE_W-1:0] rd_size_q;

  logic              evict, pop_now, wr_en;
  logic [SIZE_W:0]   sum_bytes;
  logic [SIZE_W-1:0] bytes_after_pop;

  // oldest entry must go while the queue is at its limit or the new size won't fit
  assign sum_bytes = {1'b0, bytes_q} + {1'b0, cur_q.size};
  assign evict     = (held_q != '0) &&
                     ((held_q >= limit_i) || (sum_bytes > {1'b0, max_bytes_i}));
  assign pop_now   = (state_q == ST_POP) || ((state_q == ST_PUT) && evict);
  assign wr_en     = (state_q == ST_PUT) && !evict;
  assign op_pop_o  = (state_q == ST_IDLE) && op_valid_i;
  assign idle_o    = (state_q == ST_IDLE);

  assign bytes_after_pop = (bytes_q >= rd_size_q) ? bytes_q - rd_size_q : '0;

  // read port follows the next head, so read data matches head_q whenever an entry is popped
  always_comb begin
    head_d = head_q;
    if (pop_now) begin
      head_d = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[tail_q]  <= cur_q.tag;
      size_mem[tail_q] <= cur_q.size;
    end
    rd_tag_q  <= tag_mem[head_d];
    rd_size_q <= size_mem[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '{kind: OP_NOP, size: '0, tag: '0};
      head_q    <= '0;
      tail_q    <= '0;
      held_q    <= '0;
      bytes_q   <= '0;
      dropped_q <= '0;
      res_q     <= '0;
    end else begin
      res_q.done <= 1'b0;
      head_q     <= head_d;
      case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            cur_q         <= op_i;
            dropped_q     <= '0;
            res_q.status  <= STS_OK;
            res_q.dropped <= '0;
            res_q.tag     <= '0;
            res_q.size    <= '0;
            res_q.count   <= held_q;
            res_q.bytes   <= bytes_q;
            case (op_i.kind)
              OP_PUT: begin
                state_q <= ST_PUT;
              end
              OP_GET, OP_DROP: begin
                if (held_q == '0) begin
                  res_q.done   <= 1'b1;
                  res_q.status <= STS_EMPTY;
                end else begin
                  state_q <= ST_POP;
                end
              end
              OP_REJECT: begin
                res_q.done   <= 1'b1;
                res_q.status <= STS_TOOBIG;
              end
              default: begin
                res_q.done <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          held_q      <= held_q - CNT_W'(1);
          bytes_q     <= bytes_after_pop;
          res_q.done  <= 1'b1;
          res_q.count <= held_q - CNT_W'(1);
          res_q.bytes <= bytes_after_pop;
          if (cur_q.kind == OP_GET) begin
            res_q.tag  <= rd_tag_q;
            res_q.size <= rd_size_q;
          end
          state_q <= ST_IDLE;
        end
        ST_PUT: begin
          if (evict) begin
            held_q    <= held_q - CNT_W'(1);
            bytes_q   <= bytes_after_pop;
            dropped_q <= dropped_q + CNT_W'(1);
          end else begin
            tail_q        <= (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);
            held_q        <= held_q + CNT_W'(1);
            bytes_q       <= sum_bytes[SIZE_W-1:0];
            res_q.done    <= 1'b1;
            res_q.dropped <= dropped_q;
            res_q.count   <= held_q + CNT_W'(1);
            res_q.bytes   <= sum_bytes[SIZE_W-1:0];
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

FILE: test/drop_oldest_byte_budget_queue_core_tb.sv
`timescale 1ns / 1ps

module drop_oldest_byte_budget_queue_core_tb;
  import dobq_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0]           CMD_IGNORED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int NUM_SCRIPT      = 21;
  localparam int NUM_PHASES      = 10;
  localparam int WORDS_PER_PHASE = 93;

  // one reply word, field for field as it leaves the block
  typedef struct packed {
    logic [1:0]        status;
    logic [CNT_W-1:0]  dropped;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    logic [SIZE_W-1:0] bytes;
  } queue_reply_t;

  localparam queue_reply_t NO_REPLY = '0;

  // directed row: typed = 1 means the reply below is the expectation,
  // otherwise the queue model decides
  typedef struct packed {
    bit                typed;
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    queue_reply_t      reply;
  } script_row_t;

  // Rows run with the reset budget: 64 entries, 65536 bytes.
  localparam script_row_t SCRIPT [NUM_SCRIPT] = '{
    // empty queue: get and drop both report empty
    '{1'b1, CMD_GET,     24'h0,      16'h0,
      '{STS_EMPTY, 7'd0, 16'h0, 24'h0, 7'd0, 24'h0}},
    '{1'b1, CMD_DROP,    24'h0,      16'h0,
      '{STS_EMPTY, 7'd0, 16'h0, 24'h0, 7'd0, 24'h0}},
    // unknown command, all-ones payload: nothing happens
    '{1'b1, CMD_IGNORED, 24'hFFFFFF, 16'hFFFF,
      '{STS_OK, 7'd0, 16'h0, 24'h0, 7'd0, 24'h0}},
    // one byte over the budget, and the largest size
    '{1'b1, CMD_PUT,     24'd65537,  16'hFFFF,
      '{STS_TOOBIG, 7'd0, 16'h0, 24'h0, 7'd0, 24'h0}},
    '{1'b1, CMD_PUT,     24'hFFFFFF, 16'h0,
      '{STS_TOOBIG, 7'd0, 16'h0, 24'h0, 7'd0, 24'h0}},
    // zero-byte word, then one that fills the budget exactly
    '{1'b1, CMD_PUT,     24'h0,      16'h0,
      '{STS_OK, 7'd0, 16'h0, 24'h0, 7'd1, 24'h0}},
    '{1'b1, CMD_PUT,     24'd65536,  16'hFFFF,
      '{STS_OK, 7'd0, 16'h0, 24'h0, 7'd2, 24'd65536}},
    // one more byte evicts both
    '{1'b0, CMD_PUT,     24'd1,      16'h1234, NO_REPLY},
    '{1'b0, CMD_PUT,     24'd65535,  16'h0001, NO_REPLY},
    '{1'b0, CMD_GET,     24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_GET,     24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_GET,     24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_PUT,     24'd100,    16'hAAAA, NO_REPLY},
    '{1'b0, CMD_PUT,     24'd200,    16'h5555, NO_REPLY},
    '{1'b0, CMD_PUT,     24'd300,    16'h0F0F, NO_REPLY},
    '{1'b0, CMD_DROP,    24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_GET,     24'h0,      16'h0,    NO_REPLY},
    // unknown command on a non-empty queue keeps the counts
    '{1'b0, CMD_IGNORED, 24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_PUT,     24'd65536,  16'h8000, NO_REPLY},
    '{1'b0, CMD_DROP,    24'h0,      16'h0,    NO_REPLY},
    '{1'b0, CMD_DROP,    24'h0,      16'h0,    NO_REPLY}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            command_i;
  logic [SIZE_W-1:0]     item_size_i;
  logic [TAG_W-1:0]      item_tag_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [CNT_W-1:0]      dropped_count_o;
  logic [TAG_W-1:0]      out_tag_o;
  logic [SIZE_W-1:0]     out_size_o;
  logic [CNT_W-1:0]      entry_count_o;
  logic [SIZE_W-1:0]     byte_total_o;

  drop_oldest_byte_budget_queue_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .item_size_i    (item_size_i),
    .item_tag_i     (item_tag_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .dropped_count_o(dropped_count_o),
    .out_tag_o      (out_tag_o),
    .out_size_o     (out_size_o),
    .entry_count_o  (entry_count_o),
    .byte_total_o   (byte_total_o)
  );

  // ---------------------------------------------------------------------------
  // Queue model: mirror of the descriptor ring, its counters and the budget.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0]     q_tag  [DEPTH];
  logic [SIZE_W-1:0]    q_size [DEPTH];
  logic [IDX_W-1:0]     q_head  = '0;
  logic [IDX_W-1:0]     q_tail  = '0;
  logic [CNT_W-1:0]     q_count = '0;
  logic [SIZE_W-1:0]    q_bytes = '0;
  logic [ENT_CFG_W-1:0] lim_entries = MAX_ENTRIES_RST;
  logic [SIZE_W-1:0]    lim_bytes   = MAX_BYTES_RST;

  queue_reply_t pending_replies [$];
  int           err_count = 0;

  function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // unlink the oldest descriptor; byte total never goes below zero
  function automatic void take_oldest(output logic [TAG_W-1:0] tag,
                                      output logic [SIZE_W-1:0] size);
    tag     = q_tag[q_head];
    size    = q_size[q_head];
    q_head  = next_idx(q_head);
    q_count = q_count - 1'b1;
    q_bytes = (q_bytes >= size) ? q_bytes - size : '0;
  endfunction

  function automatic queue_reply_t apply_command(logic [1:0] cmd, logic [SIZE_W-1:0] size,
                                                 logic [TAG_W-1:0] tag);
    queue_reply_t      r;
    int unsigned       lim;
    logic [TAG_W-1:0]  gone_tag;
    logic [SIZE_W-1:0] gone_size;
    r = '0;
    // entry limit 0 acts as 1, anything above the ring depth saturates
    lim = (lim_entries == 0) ? 1 : ((lim_entries > DEPTH) ? DEPTH : lim_entries);
    case (cmd)
      CMD_PUT: begin
        if (size > lim_bytes) begin
          r.status = STS_TOOBIG;
        end else begin
          // evict from the head until both the count and the bytes fit
          while (q_count > 0 && (q_count >= lim ||
                 64'(q_bytes) + 64'(size) > 64'(lim_bytes))) begin
            take_oldest(gone_tag, gone_size);
            r.dropped = r.dropped + 1'b1;
          end
          q_tag[q_tail]  = tag;
          q_size[q_tail] = size;
          q_tail         = next_idx(q_tail);
          q_count        = q_count + 1'b1;
          q_bytes        = q_bytes + size;
        end
      end
      CMD_GET, CMD_DROP: begin
        if (q_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          take_oldest(gone_tag, gone_size);
          if (cmd == CMD_GET) begin
            r.tag  = gone_tag;
            r.size = gone_size;
          end
        end
      end
      default: ;  // unknown command: queue untouched
    endcase
    r.count = q_count;
    r.bytes = q_bytes;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fail the run if it hangs past the timeout
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Reply checker: every strobe pops the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    queue_reply_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("reply strobe with no command outstanding");
        err_count++;
      end else begin
        e = pending_replies.pop_front();
        check_field("status",        32'(e.status),  32'(status_o));
        check_field("dropped_count", 32'(e.dropped), 32'(dropped_count_o));
        check_field("out_tag",       32'(e.tag),     32'(out_tag_o));
        check_field("out_size",      32'(e.size),    32'(out_size_o));
        check_field("entry_count",   32'(e.count),   32'(entry_count_o));
        check_field("byte_total",    32'(e.bytes),   32'(byte_total_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  // Present one word after an idle stretch set by `gap`; start stays high when gap is 0
  // so back-to-back words just swap payload at the falling edge.
  task automatic issue_word(input logic [1:0] cmd, input logic [SIZE_W-1:0] size,
                            input logic [TAG_W-1:0] tag, input int unsigned gap,
                            input bit typed, input queue_reply_t typed_reply);
    queue_reply_t predicted;
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    command_i   <= cmd;
    item_size_i <= size;
    item_tag_i  <= tag;
    // taken on the first rising edge that sees busy low
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = apply_command(cmd, size, tag);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // drop start and hold off until every reply is back
  task automatic settle_queue();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // registers change only with the queue idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_MAX_ENTRIES: lim_entries = data[ENT_CFG_W-1:0];
      REG_MAX_BYTES:   lim_bytes   = data[SIZE_W-1:0];
      default: ;  // spare indexes are ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] ent_data;
    logic [CFG_DATA_W-1:0] byte_data;
    logic [1:0]            cmd;
    logic [SIZE_W-1:0]     size;
    int unsigned           budget;
    int unsigned           put_pct;
    int unsigned           pick;
    int unsigned           gap;
    bit                    steady;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    command_i   = CMD_PUT;
    item_size_i = '0;
    item_tag_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_MAX_ENTRIES;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at the reset budget
    foreach (SCRIPT[i])
      issue_word(SCRIPT[i].cmd, SCRIPT[i].size, SCRIPT[i].tag, $urandom_range(0, 12),
                 SCRIPT[i].typed, SCRIPT[i].reply);

    // random phases, each under its own budget; the first few pin the extremes
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_queue();
      case (p)
        0: begin  // entry limit 0 behaves as 1; junk above bit 6 is ignored
          ent_data  = {17'($urandom), 7'd0};
          byte_data = 24'hFFFFFF;
          put_pct   = 60;
        end
        1: begin  // only zero-byte words fit
          ent_data  = 24'd1;
          byte_data = 24'd0;
          put_pct   = 60;
        end
        2: begin  // limit 127 saturates to the ring depth; fill it up
          ent_data  = {17'($urandom), 7'd127};
          byte_data = 24'hFFFFFF;
          put_pct   = 92;
        end
        3: begin
          ent_data  = 24'd64;
          byte_data = 24'd65536;
          put_pct   = 70;
        end
        4: begin
          ent_data  = 24'd2;
          byte_data = 24'd1000;
          put_pct   = 65;
        end
        default: begin
          ent_data = 24'($urandom);
          case ($urandom_range(0, 2))
            0:       byte_data = 24'($urandom_range(0, 255));
            1:       byte_data = 24'($urandom_range(0, 1 << 16));
            default: byte_data = 24'($urandom);
          endcase
          put_pct = $urandom_range(45, 85);
        end
      endcase
      write_reg(REG_MAX_ENTRIES, ent_data);
      write_reg(REG_MAX_BYTES, byte_data);
      // spare indexes must not disturb the budget
      if (p == 5 || $urandom_range(0, 3) == 0) begin
        write_reg(REG_SPARE_A, 24'($urandom));
        write_reg(REG_SPARE_B, 24'($urandom));
      end

      budget = lim_bytes;
      steady = (p % 3 == 1);  // some phases issue every word with a gap of 0
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // now and then let the queue run dry mid-phase
        if ($urandom_range(0, 49) == 0) settle_queue();

        pick = $urandom_range(0, 99);
        if (pick < put_pct) begin
          cmd = CMD_PUT;
        end else begin
          case ($urandom_range(0, 9))
            0:             cmd = CMD_IGNORED;
            1, 2, 3, 4, 5: cmd = CMD_GET;
            default:       cmd = CMD_DROP;
          endcase
        end

        pick = $urandom_range(0, 99);
        if (pick < 5)
          size = '0;
        else if (pick < 10)
          size = SIZE_W'(budget);
        else if (pick < 15)  // over budget, unless the budget is already the top
          size = (budget == 24'hFFFFFF) ? SIZE_W'(budget)
                                        : SIZE_W'($urandom_range(budget + 1, 24'hFFFFFF));
        else if (pick < 22)  // big word, evicts a lot
          size = SIZE_W'($urandom_range(budget / 2, budget));
        else
          size = SIZE_W'($urandom_range(0, budget >> $urandom_range(4, 10)));

        gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        issue_word(cmd, size, TAG_W'($urandom), gap, 1'b0, NO_REPLY);
      end
    end

    // drain, then watch a while for stray strobes
    settle_queue();
    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
